[rtl/tombstone_array_list_engine_top_macros.svh]
// assertion macros for the tombstone array list engine
`ifndef TOMBSTONE_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define TOMBSTONE_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define TALE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define TALE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/tale_pkg.sv]
// package with command and status codes for the tombstone array list engine
package tale_pkg;
  localparam int DEPTH = 1024;
  localparam int HANDLE_WIDTH = 32;
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_ADD_ABSENT = 4'd1, CMD_INSERT_AT = 4'd2, CMD_REM_VAL = 4'd3,
    CMD_REM_VALID = 4'd4, CMD_REM_RAW = 4'd5, CMD_REPL_VAL = 4'd6, CMD_REPL_VALID = 4'd7,
    CMD_GET_VALID = 4'd8, CMD_GET_RAW = 4'd9, CMD_NEXT = 4'd10, CMD_CONTAINS = 4'd11,
    CMD_LOCATE = 4'd12, CMD_COMPRESS = 4'd13, CMD_RSV14 = 4'd14, CMD_RSV15 = 4'd15
  } cmd_t;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOTFOUND = 3'd1, ST_FULL = 3'd2, ST_RANGE = 3'd3, ST_ZERO = 3'd4
  } status_t;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_SHIFT = 6'b000100,
    S_PACK = 6'b001000, S_FIN = 6'b010000, S_DONE = 6'b100000
  } state_t;
endpackage

[rtl/tombstone_array_list_engine_top.sv]
// top level of the tombstone array list engine
// A request is taken when start is high and busy is low; its single result appears
// for one cycle with out_valid and cannot be held off. A command that searches scans
// the slot memory through its one read port, one slot per cycle. Compress packs the
// store in a single pass over that port. Insert in the middle then moves the tail up
// one slot, reading and then writing back each slot moved.
// busy stays high from acceptance to the result.
`include "tombstone_array_list_engine_top_macros.svh"
module tombstone_array_list_engine_top import tale_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [10:0] in_slot_index,
  input  logic [31:0] in_new_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_value_out,
  output logic [10:0] out_index_out,
  output logic [10:0] out_valid_count,
  output logic [10:0] out_raw_size
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [HANDLE_WIDTH-1:0] mem [DEPTH];
  logic [HANDLE_WIDTH-1:0] rd_data;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [HANDLE_WIDTH-1:0] wr_data;
  logic                    rd_en, wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [HANDLE_WIDTH-1:0] val_r, val_nxt, nval_r, nval_nxt, carry_r, carry_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [CW-1:0] live_r, live_nxt, gap_r, gap_nxt, fgap_r, fgap_nxt;
  logic [CW-1:0] pos_r, pos_nxt, wpos_r, wpos_nxt, cnt_r, cnt_nxt;
  logic rdv_r, rdv_nxt;
  logic [2:0] st_r, st_nxt;
  logic [HANDLE_WIDTH-1:0] vout_r, vout_nxt;
  logic [10:0] iout_r, iout_nxt;
  logic ov_r, ov_nxt;

  logic [CW-1:0] fill;
  logic [HANDLE_WIDTH-1:0] hv, hnv;
  logic [CW:0] idx_w;
  logic hit;

  assign fill = live_r + gap_r;
  assign hv   = in_value[HANDLE_WIDTH-1:0];
  assign hnv  = in_new_value[HANDLE_WIDTH-1:0];
  assign idx_w = (CW+1)'(in_slot_index);

  // match test on the slot read in the previous cycle
  always_comb begin
    hit = 1'b0;
    case (cmd_r)
      CMD_ADD_ABSENT, CMD_REM_VAL, CMD_REPL_VAL, CMD_CONTAINS, CMD_LOCATE:
        hit = (rd_data == val_r);
      CMD_INSERT_AT, CMD_REM_VALID, CMD_REPL_VALID, CMD_GET_VALID:
        hit = (rd_data != '0) && (cnt_r == CW'(idx_r));
      CMD_NEXT: hit = (rd_data != '0);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; val_nxt = val_r; nval_nxt = nval_r;
    idx_nxt = idx_r; live_nxt = live_r; gap_nxt = gap_r; fgap_nxt = fgap_r;
    pos_nxt = pos_r; wpos_nxt = wpos_r; cnt_nxt = cnt_r; rdv_nxt = 1'b0;
    carry_nxt = carry_r; st_nxt = st_r; vout_nxt = vout_r; iout_nxt = iout_r;
    ov_nxt = 1'b0;
    rd_en = 1'b0; rd_addr = pos_r[AW-1:0];
    wr_en = 1'b0; wr_addr = pos_r[AW-1:0]; wr_data = val_r;
    case (state_r)
      S_IDLE: begin
        if (start && !ov_r) begin
          cmd_nxt = cmd_t'(in_command); val_nxt = hv; nval_nxt = hnv;
          idx_nxt = in_slot_index; st_nxt = ST_OK; vout_nxt = '0; iout_nxt = '0;
          pos_nxt = '0; cnt_nxt = '0; state_nxt = S_DONE;
          case (cmd_t'(in_command))
            CMD_ADD, CMD_ADD_ABSENT: begin
              if (hv == '0) st_nxt = ST_ZERO;
              else if (in_command == CMD_ADD_ABSENT && fill != '0) state_nxt = S_SCAN;
              else if (fill >= DEPTH_C) st_nxt = ST_FULL;
              else begin
                wr_en = 1'b1; wr_addr = fill[AW-1:0]; wr_data = hv;
                live_nxt = live_r + 1'b1;
              end
            end
            CMD_INSERT_AT: begin
              if (hv == '0) st_nxt = ST_ZERO;
              else if (idx_w > (CW+1)'(live_r)) st_nxt = ST_RANGE;
              else if (fill >= DEPTH_C) st_nxt = ST_FULL;
              else if (idx_w == (CW+1)'(live_r)) begin
                wr_en = 1'b1; wr_addr = fill[AW-1:0]; wr_data = hv;
                live_nxt = live_r + 1'b1;
              end else state_nxt = S_SCAN;
            end
            CMD_REM_VAL, CMD_REPL_VAL, CMD_CONTAINS, CMD_LOCATE: begin
              if (hv == '0 || (in_command == CMD_REPL_VAL && hnv == '0)) st_nxt = ST_ZERO;
              else if (fill == '0) st_nxt = ST_NOTFOUND;
              else state_nxt = S_SCAN;
            end
            CMD_REM_VALID, CMD_GET_VALID, CMD_REPL_VALID: begin
              if (in_command == CMD_REPL_VALID && hnv == '0) st_nxt = ST_ZERO;
              else if (idx_w >= (CW+1)'(live_r)) st_nxt = ST_RANGE;
              else state_nxt = S_SCAN;
            end
            CMD_REM_RAW, CMD_GET_RAW, CMD_NEXT: begin
              if (in_command == CMD_NEXT) iout_nxt = in_slot_index;
              if (idx_w >= (CW+1)'(fill)) st_nxt = ST_RANGE;
              else begin
                pos_nxt = CW'(in_slot_index); state_nxt = S_SCAN;
              end
            end
            CMD_COMPRESS: begin
              if (fill != '0) begin
                wpos_nxt = '0; state_nxt = S_PACK;
              end else begin
                gap_nxt = '0; fgap_nxt = DEPTH_C;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // issue read at pos_r while checking the previous read
        if (rdv_r && (hit || cmd_r == CMD_REM_RAW || cmd_r == CMD_GET_RAW)) begin
          state_nxt = S_FIN;
        end else if (pos_r >= fill) begin
          case (cmd_r)
            CMD_ADD_ABSENT: begin
              if (fill >= DEPTH_C) st_nxt = ST_FULL;
              else begin
                wr_en = 1'b1; wr_addr = fill[AW-1:0]; wr_data = val_r;
                live_nxt = live_r + 1'b1;
              end
            end
            default: st_nxt = ST_NOTFOUND;
          endcase
          state_nxt = S_DONE;
        end else begin
          rd_en = 1'b1; rdv_nxt = 1'b1; pos_nxt = pos_r + 1'b1;
          if (rdv_r && rd_data != '0) cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        // matched slot sits at pos_r - 1, its data still in rd_data
        wr_addr = AW'(pos_r - 1'b1);
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_REM_VAL, CMD_REM_VALID, CMD_REM_RAW: begin
            if (cmd_r != CMD_REM_VAL) vout_nxt = rd_data;
            if (rd_data != '0) begin
              wr_en = 1'b1; wr_data = '0;
              live_nxt = live_r - 1'b1; gap_nxt = gap_r + 1'b1;
              if ((pos_r - 1'b1) < fgap_r) fgap_nxt = pos_r - 1'b1;
            end
          end
          CMD_REPL_VAL, CMD_REPL_VALID: begin
            wr_en = 1'b1; wr_data = nval_r;
          end
          CMD_GET_VALID, CMD_GET_RAW: vout_nxt = rd_data;
          CMD_NEXT: begin
            vout_nxt = rd_data; iout_nxt = 11'(pos_r);
          end
          CMD_LOCATE: iout_nxt = 11'(cnt_r);
          CMD_INSERT_AT: begin
            // write new handle, then ripple the tail up by one
            wr_en = 1'b1; wr_data = val_r; carry_nxt = rd_data;
            if (fgap_r < DEPTH_C && fgap_r > (pos_r - 1'b1)) fgap_nxt = fgap_r + 1'b1;
            live_nxt = live_r + 1'b1;
            wpos_nxt = pos_r; state_nxt = S_SHIFT;
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // alternate: read slot wpos, then write carry there; last slot is fill - 1
        if (!rdv_r) begin
          if (wpos_r + 1'b1 >= fill) begin
            wr_en = 1'b1; wr_addr = wpos_r[AW-1:0]; wr_data = carry_r;
            state_nxt = S_DONE;
          end else begin
            rd_en = 1'b1; rd_addr = wpos_r[AW-1:0]; rdv_nxt = 1'b1;
          end
        end else begin
          wr_en = 1'b1; wr_addr = wpos_r[AW-1:0]; wr_data = carry_r;
          carry_nxt = rd_data; wpos_nxt = wpos_r + 1'b1;
        end
      end
      S_PACK: begin
        if (rdv_r && rd_data != '0) begin
          wr_en = 1'b1; wr_addr = wpos_r[AW-1:0]; wr_data = rd_data;
          wpos_nxt = wpos_r + 1'b1;
        end
        if (pos_r >= fill) begin
          if (!rdv_r) begin
            gap_nxt = '0; fgap_nxt = DEPTH_C; state_nxt = S_DONE;
          end
        end else begin
          rd_en = 1'b1; rdv_nxt = 1'b1; pos_nxt = pos_r + 1'b1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; live_r <= '0; gap_r <= '0; fgap_r <= DEPTH_C;
      rdv_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; live_r <= live_nxt; gap_r <= gap_nxt; fgap_r <= fgap_nxt;
      rdv_r <= rdv_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; val_r <= val_nxt; nval_r <= nval_nxt; idx_r <= idx_nxt;
    pos_r <= pos_nxt; wpos_r <= wpos_nxt; cnt_r <= cnt_nxt; carry_r <= carry_nxt;
    st_r <= st_nxt; vout_r <= vout_nxt; iout_r <= iout_nxt;
  end

  assign busy = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_value_out = 32'(vout_r);
  assign out_index_out = iout_r;
  assign out_valid_count = 11'(live_r);
  assign out_raw_size = 11'(fill);

  `TALE_ASSERT_IMP(a_fill_bound, 1'b1, fill <= DEPTH_C)
  `TALE_ASSERT_NXT(a_one_result, out_valid, !out_valid)
  `TALE_ASSERT_IMP(a_busy_result, out_valid, busy)
  `TALE_ASSERT_IMP(a_no_gap_no_first, gap_r == '0, fgap_r == DEPTH_C || state_r != S_IDLE)
endmodule
